// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the chtab_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== hw/rtl/chtab_pkg.sv =====
package chtab_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned BUCKET_RESET      = 256;
  localparam int unsigned BUCKET_MIN        = 3;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int unsigned MIX_S1 = 30;
  localparam int unsigned MIX_S2 = 27;
  localparam int unsigned MIX_S3 = 31;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam logic [2:0] ST_NOT_FOUND = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_UPDATED   = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL_CLR  = 3'd5;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_out;
  } rsp_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_MOD
  } hash_state_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_HASH,
    C_RD_ROOT,
    C_ROOT,
    C_RD_SUCC,
    C_SUCC,
    C_FREE,
    C_WALK,
    C_CMP,
    C_RD_FREE,
    C_ALLOC,
    C_LINKROOT,
    C_CLR,
    C_FIN
  } ctl_state_t;

  // Effective root count: register value held to [BUCKET_MIN, max_nb].
  function automatic int unsigned clamp_nb(logic [8:0] bc, int unsigned max_nb);
    int unsigned v;
    v = int'(bc);
    if (v < BUCKET_MIN) v = BUCKET_MIN;
    if (v > max_nb) v = max_nb;
    return v;
  endfunction

endpackage

// ===== hw/rtl/chtab_ram.sv =====
module chtab_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/chtab_hash.sv =====
module chtab_hash #(
  parameter int unsigned TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [63:0]                      key,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] nb,
  output logic                             done,
  output logic [$clog2(TABLE_ENTRIES)-1:0] root
);

  localparam int unsigned LW = $clog2(TABLE_ENTRIES);

  chtab_pkg::hash_state_t state_r, state_nxt;
  logic [1:0]  ph_r;
  logic        msel_r;
  logic [4:0]  bit_r;
  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [31:0] d_r;
  logic [LW-1:0] rem_r;

  logic [63:0] b_op;
  logic [31:0] ma, mb;
  logic [63:0] acc_fin;
  logic [LW:0] trial;

  assign b_op    = msel_r ? chtab_pkg::MIX_C2 : chtab_pkg::MIX_C1;
  assign acc_fin = acc_r + {prod_r[31:0], 32'd0};
  assign trial   = {rem_r, d_r[31]};
  assign root    = rem_r;

  // partial products of the low 64 bits: aL*bL, aH*bL<<32, aL*bH<<32
  always_comb begin
    case (ph_r)
      2'd0:    begin ma = a_r[31:0];  mb = b_op[31:0];  end
      2'd1:    begin ma = a_r[63:32]; mb = b_op[31:0];  end
      default: begin ma = a_r[31:0];  mb = b_op[63:32]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chtab_pkg::H_IDLE: if (start) state_nxt = chtab_pkg::H_MUL;
      chtab_pkg::H_MUL:  if (ph_r == 2'd3 && msel_r) state_nxt = chtab_pkg::H_MOD;
      chtab_pkg::H_MOD:  if (bit_r == 5'd31) state_nxt = chtab_pkg::H_IDLE;
      default: state_nxt = chtab_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == chtab_pkg::H_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chtab_pkg::H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      chtab_pkg::H_IDLE: begin
        if (start) begin
          a_r    <= key ^ (key >> chtab_pkg::MIX_S1);
          ph_r   <= 2'd0;
          msel_r <= 1'b0;
        end
      end
      chtab_pkg::H_MUL: begin
        prod_r <= 64'(ma) * 64'(mb);
        ph_r   <= ph_r + 2'd1;
        case (ph_r)
          2'd1:    acc_r <= prod_r;
          2'd2:    acc_r <= acc_fin;
          2'd3: begin
            if (!msel_r) begin
              a_r    <= acc_fin ^ (acc_fin >> chtab_pkg::MIX_S2);
              msel_r <= 1'b1;
            end else begin
              d_r   <= acc_fin[31:0] ^ acc_fin[31+chtab_pkg::MIX_S3:chtab_pkg::MIX_S3];
              rem_r <= '0;
              bit_r <= 5'd0;
            end
          end
          default: ;
        endcase
      end
      chtab_pkg::H_MOD: begin
        // restoring division, one quotient bit a cycle
        if (trial >= {1'b0, nb}) begin
          rem_r <= LW'(trial - {1'b0, nb});
        end else begin
          rem_r <= trial[LW-1:0];
        end
        d_r   <= {d_r[30:0], 1'b0};
        bit_r <= bit_r + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/chtab_ctrl.sv =====
module chtab_ctrl #(
  parameter int unsigned TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] nb,
  input  logic [$clog2(TABLE_ENTRIES):0]   size,
  input  logic                             restart,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  chtab_pkg::req_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output chtab_pkg::rsp_t                  out_data,
  output logic                             hash_start,
  input  logic                             hash_done,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] hash_root
);

  localparam int unsigned LW = $clog2(TABLE_ENTRIES);
  localparam logic [LW-1:0] LINK_EMPTY = LW'(0);
  localparam logic [LW-1:0] LINK_END   = LW'(1);

  chtab_pkg::ctl_state_t state_r, state_nxt;
  chtab_pkg::req_t req_r;
  logic [LW-1:0] root_r, prev_r, pos_r, rootlink_r, fh_r, idx_r;
  logic [LW:0]   steps_r;
  logic          clr_reply_r;
  logic [2:0]    status_r;
  logic [63:0]   vout_r;
  logic          out_valid_r;
  chtab_pkg::rsp_t out_data_r;

  logic          lk_we, ky_we, vl_we;
  logic [LW-1:0] waddr, raddr, lk_wd, lk_rd;
  logic [63:0]   ky_wd, vl_wd, ky_rd, vl_rd;

  logic in_fire, slot_free, is_ins, is_rem, is_look, hit;
  logic lk_ovf, pos_ovf, fh_ovf, clr_last;

  function automatic logic ovf(logic [LW-1:0] p, logic [LW-1:0] n, logic [LW:0] s);
    return (p >= n) && ({1'b0, p} < s);
  endfunction

  assign in_ready  = (state_r == chtab_pkg::C_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_ins    = (req_r.kind == chtab_pkg::KIND_INSERT);
  assign is_rem    = (req_r.kind == chtab_pkg::KIND_REMOVE);
  assign is_look   = (req_r.kind == chtab_pkg::KIND_LOOKUP);
  assign hit       = (ky_rd == req_r.key);
  assign lk_ovf    = ovf(lk_rd, nb, size);
  assign pos_ovf   = ovf(pos_r, nb, size) && (steps_r < size);
  assign fh_ovf    = ovf(fh_r, nb, size);
  assign clr_last  = ({1'b0, idx_r} == size - 1'b1);

  chtab_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_link (
    .clk(clk), .we(lk_we), .waddr(waddr), .wdata(lk_wd), .raddr(raddr), .rdata(lk_rd)
  );
  chtab_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_key (
    .clk(clk), .we(ky_we), .waddr(waddr), .wdata(ky_wd), .raddr(raddr), .rdata(ky_rd)
  );
  chtab_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_val (
    .clk(clk), .we(vl_we), .waddr(waddr), .wdata(vl_wd), .raddr(raddr), .rdata(vl_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chtab_pkg::C_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.kind == chtab_pkg::KIND_CLEAR) ? chtab_pkg::C_CLR
                                                             : chtab_pkg::C_HASH;
        end
      end
      chtab_pkg::C_HASH:    if (hash_done) state_nxt = chtab_pkg::C_RD_ROOT;
      chtab_pkg::C_RD_ROOT: state_nxt = chtab_pkg::C_ROOT;
      chtab_pkg::C_ROOT: begin
        if (lk_rd == LINK_EMPTY) state_nxt = chtab_pkg::C_FIN;
        else if (hit) state_nxt = (is_rem && lk_ovf) ? chtab_pkg::C_RD_SUCC : chtab_pkg::C_FIN;
        else state_nxt = chtab_pkg::C_WALK;
      end
      chtab_pkg::C_RD_SUCC: state_nxt = chtab_pkg::C_SUCC;
      chtab_pkg::C_SUCC:    state_nxt = chtab_pkg::C_FREE;
      chtab_pkg::C_FREE:    state_nxt = chtab_pkg::C_FIN;
      chtab_pkg::C_WALK: begin
        if (pos_ovf) state_nxt = chtab_pkg::C_CMP;
        else if (is_ins && fh_ovf) state_nxt = chtab_pkg::C_RD_FREE;
        else state_nxt = chtab_pkg::C_FIN;
      end
      chtab_pkg::C_CMP: begin
        if (hit) state_nxt = is_rem ? chtab_pkg::C_FREE : chtab_pkg::C_FIN;
        else state_nxt = chtab_pkg::C_WALK;
      end
      chtab_pkg::C_RD_FREE:  state_nxt = chtab_pkg::C_ALLOC;
      chtab_pkg::C_ALLOC:    state_nxt = chtab_pkg::C_LINKROOT;
      chtab_pkg::C_LINKROOT: state_nxt = chtab_pkg::C_FIN;
      chtab_pkg::C_CLR: begin
        if (clr_last) state_nxt = clr_reply_r ? chtab_pkg::C_FIN : chtab_pkg::C_IDLE;
      end
      chtab_pkg::C_FIN: if (slot_free) state_nxt = chtab_pkg::C_IDLE;
      default: state_nxt = chtab_pkg::C_IDLE;
    endcase
    if (restart) state_nxt = chtab_pkg::C_CLR;
  end

  always_comb begin
    lk_we      = 1'b0;
    ky_we      = 1'b0;
    vl_we      = 1'b0;
    waddr      = root_r;
    lk_wd      = LINK_EMPTY;
    ky_wd      = req_r.key;
    vl_wd      = req_r.value;
    raddr      = pos_r;
    hash_start = 1'b0;
    case (state_r)
      chtab_pkg::C_IDLE:    hash_start = in_fire && (in_data.kind != chtab_pkg::KIND_CLEAR);
      chtab_pkg::C_RD_ROOT: raddr = root_r;
      chtab_pkg::C_ROOT: begin
        if (lk_rd == LINK_EMPTY) begin
          lk_we = is_ins;
          ky_we = is_ins;
          vl_we = is_ins;
          lk_wd = LINK_END;
        end else if (hit) begin
          vl_we = is_ins;
          lk_we = is_rem && !lk_ovf;
        end
      end
      chtab_pkg::C_SUCC: begin
        // pull successor into the root slot
        lk_we = 1'b1;
        ky_we = 1'b1;
        vl_we = 1'b1;
        lk_wd = lk_rd;
        ky_wd = ky_rd;
        vl_wd = vl_rd;
      end
      chtab_pkg::C_FREE: begin
        lk_we = 1'b1;
        waddr = pos_r;
        lk_wd = fh_r;
      end
      chtab_pkg::C_CMP: begin
        if (hit) begin
          vl_we = is_ins;
          lk_we = is_rem;
          waddr = is_rem ? prev_r : pos_r;
          lk_wd = lk_rd;
        end
      end
      chtab_pkg::C_RD_FREE: raddr = fh_r;
      chtab_pkg::C_ALLOC: begin
        lk_we = 1'b1;
        ky_we = 1'b1;
        vl_we = 1'b1;
        waddr = fh_r;
        lk_wd = rootlink_r;
      end
      chtab_pkg::C_LINKROOT: begin
        lk_we = 1'b1;
        lk_wd = pos_r;
      end
      chtab_pkg::C_CLR: begin
        lk_we = 1'b1;
        waddr = idx_r;
        if (idx_r < nb) lk_wd = LINK_EMPTY;
        else if (clr_last) lk_wd = LINK_END;
        else lk_wd = idx_r + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chtab_pkg::C_CLR;
      idx_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chtab_pkg::C_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        idx_r       <= '0;
        clr_reply_r <= 1'b0;
      end else begin
        case (state_r)
          chtab_pkg::C_IDLE: begin
            if (in_fire) begin
              req_r       <= in_data;
              status_r    <= (in_data.kind == chtab_pkg::KIND_CLEAR) ? chtab_pkg::ST_FULL_CLR
                                                                     : chtab_pkg::ST_NOT_FOUND;
              vout_r      <= '0;
              idx_r       <= '0;
              clr_reply_r <= 1'b1;
            end
          end
          chtab_pkg::C_HASH: root_r <= hash_root;
          chtab_pkg::C_ROOT: begin
            rootlink_r <= lk_rd;
            pos_r      <= lk_rd;
            prev_r     <= root_r;
            steps_r    <= '0;
            if (lk_rd == LINK_EMPTY) begin
              if (is_ins) status_r <= chtab_pkg::ST_INSERTED;
            end else if (hit) begin
              if (is_look) begin
                status_r <= chtab_pkg::ST_FOUND;
                vout_r   <= vl_rd;
              end else if (is_ins) begin
                status_r <= chtab_pkg::ST_UPDATED;
              end else begin
                status_r <= chtab_pkg::ST_REMOVED;
              end
            end
          end
          chtab_pkg::C_FREE: fh_r <= pos_r;
          chtab_pkg::C_WALK: begin
            if (!pos_ovf && is_ins) begin
              status_r <= fh_ovf ? chtab_pkg::ST_INSERTED : chtab_pkg::ST_FULL_CLR;
            end
          end
          chtab_pkg::C_CMP: begin
            if (hit) begin
              if (is_look) begin
                status_r <= chtab_pkg::ST_FOUND;
                vout_r   <= vl_rd;
              end else if (is_ins) begin
                status_r <= chtab_pkg::ST_UPDATED;
              end else begin
                status_r <= chtab_pkg::ST_REMOVED;
              end
            end else begin
              prev_r  <= pos_r;
              pos_r   <= lk_rd;
              steps_r <= steps_r + 1'b1;
            end
          end
          chtab_pkg::C_ALLOC: begin
            fh_r  <= lk_rd;
            pos_r <= fh_r;
          end
          chtab_pkg::C_CLR: begin
            idx_r <= idx_r + LW'(1);
            if (clr_last) fh_r <= nb;
          end
          chtab_pkg::C_FIN: begin
            if (slot_free) begin
              out_data_r.status    <= status_r;
              out_data_r.value_out <= vout_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/chained_hash_table_engine_top.sv =====
// Key/value table with 64-bit keys and values, separate chaining over
// 3*roots entries held in single-port-write RAMs. One request is in
// work at a time; its result sits in an output register so the next request
// can be taken while the result waits. After a request is taken it goes
// through the hash (the two 64-bit multiplies on a shared 32x32 multiplier,
// then the bit-serial modulo by the root count, then the root handed over);
// then the root is read, each chain entry visited is read and compared, the
// walk ends on a miss, any update is written and the result is posted.
// Reset, a bucket_count write and a clear request each run a rebuild pass
// over 3*roots link entries (768 after reset), one link entry a cycle, during
// which no request is taken; a clear request answers with status 5 at its end.
// Roots are bucket_count held to [3, TABLE_ENTRIES/3].
module chained_hash_table_engine_top #(
  parameter int unsigned TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  chtab_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output chtab_pkg::rsp_t out_data,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_wdata
);

  localparam int unsigned LW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned MAX_NB = TABLE_ENTRIES / 3;

  logic [LW-1:0] nb_r, nb_nxt;
  logic [LW:0]   size_r, size_nxt;
  logic          hash_start, hash_done;
  logic [LW-1:0] hash_root;

  always_comb begin
    if (cfg_we) begin
      nb_nxt = LW'(chtab_pkg::clamp_nb(cfg_wdata, MAX_NB));
    end else begin
      nb_nxt = nb_r;
    end
    size_nxt = {1'b0, nb_nxt} + {nb_nxt, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r   <= LW'(chtab_pkg::clamp_nb(9'(chtab_pkg::BUCKET_RESET), MAX_NB));
      size_r <= (LW+1)'(3 * chtab_pkg::clamp_nb(9'(chtab_pkg::BUCKET_RESET), MAX_NB));
    end else begin
      nb_r   <= nb_nxt;
      size_r <= size_nxt;
    end
  end

  chtab_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .key(in_data.key), .nb(nb_r),
    .done(hash_done), .root(hash_root)
  );

  chtab_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .nb(nb_r), .size(size_r), .restart(cfg_we),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .hash_start(hash_start), .hash_done(hash_done), .hash_root(hash_root)
  );

endmodule

// ===== hw/rtl/chtab_checker.sv =====
`include "assert_macros.svh"

module chtab_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input chtab_pkg::rsp_t out_data
);

  // result held until taken
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CHK_IMPL(a_status_range, out_valid, out_data.status < 3'd6)
  // only a lookup hit carries a value
  `CHK_IMPL(a_vout_zero, out_valid && out_data.status != chtab_pkg::ST_FOUND,
            out_data.value_out == 64'd0)
  // one request in work at a time
  `CHK_NEXT(a_one_busy, in_valid && in_ready, !in_ready)

endmodule

bind chained_hash_table_engine_top chtab_checker u_chtab_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/chained_hash_table_engine_checker.sv =====
module chained_hash_table_engine_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  chtab_pkg::req_t in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  chtab_pkg::rsp_t out_data,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_wdata,
  output int              fail_count,
  output int              pending
);

  localparam int unsigned ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned MAX_NB  = ENTRIES / 3;

  logic [9:0]  link_mem [ENTRIES];
  logic [63:0] key_mem  [ENTRIES];
  logic [63:0] val_mem  [ENTRIES];
  logic [9:0]  free_ptr;
  logic [8:0]  bucket_reg;
  chtab_pkg::rsp_t expected_rsp [$];

  assign pending = expected_rsp.size();

  function automatic int unsigned root_count();
    int unsigned b;
    b = bucket_reg;
    if (b < chtab_pkg::BUCKET_MIN) b = chtab_pkg::BUCKET_MIN;
    if (b > MAX_NB) b = MAX_NB;
    return b;
  endfunction

  function automatic logic [31:0] splitmix32(logic [63:0] x);
    x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
    x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
    x = x ^ (x >> 31);
    return x[31:0];
  endfunction

  task automatic rebuild_table();
    int unsigned nb;
    nb = root_count();
    for (int unsigned i = 0; i < nb; i++) link_mem[i] = 10'd0;
    for (int unsigned i = nb; i + 1 < 3 * nb; i++) link_mem[i] = 10'(i + 1);
    link_mem[3 * nb - 1] = 10'd1;
    free_ptr = 10'(nb);
  endtask

  function automatic bit in_overflow(int unsigned p, int unsigned nb);
    return p >= nb && p < 3 * nb;
  endfunction

  task automatic apply_request(chtab_pkg::req_t rq);
    int unsigned nb, root, pos, prv, steps;
    bit          hit;
    chtab_pkg::rsp_t r;
    nb = root_count();
    root = splitmix32(rq.key) % nb;
    r = '0;
    r.status = chtab_pkg::ST_NOT_FOUND;
    if (rq.kind == chtab_pkg::KIND_CLEAR) begin
      rebuild_table();
      r.status = chtab_pkg::ST_FULL_CLR;
    end else if (link_mem[root] == 10'd0) begin
      if (rq.kind == chtab_pkg::KIND_INSERT) begin
        link_mem[root] = 10'd1;
        key_mem[root] = rq.key;
        val_mem[root] = rq.value;
        r.status = chtab_pkg::ST_INSERTED;
      end
    end else if (key_mem[root] == rq.key) begin
      if (rq.kind == chtab_pkg::KIND_LOOKUP) begin
        r.status = chtab_pkg::ST_FOUND;
        r.value_out = val_mem[root];
      end else if (rq.kind == chtab_pkg::KIND_INSERT) begin
        val_mem[root] = rq.value;
        r.status = chtab_pkg::ST_UPDATED;
      end else begin
        pos = link_mem[root];
        if (in_overflow(pos, nb)) begin
          // successor moves up into the root slot
          link_mem[root] = link_mem[pos];
          key_mem[root] = key_mem[pos];
          val_mem[root] = val_mem[pos];
          link_mem[pos] = free_ptr;
          free_ptr = 10'(pos);
        end else begin
          link_mem[root] = 10'd0;
        end
        r.status = chtab_pkg::ST_REMOVED;
      end
    end else begin
      hit = 0;
      prv = root;
      pos = link_mem[root];
      for (steps = 0; steps < 3 * nb && in_overflow(pos, nb); steps++) begin
        if (key_mem[pos] == rq.key) begin
          hit = 1;
          break;
        end
        prv = pos;
        pos = link_mem[pos];
      end
      if (hit) begin
        if (rq.kind == chtab_pkg::KIND_LOOKUP) begin
          r.status = chtab_pkg::ST_FOUND;
          r.value_out = val_mem[pos];
        end else if (rq.kind == chtab_pkg::KIND_INSERT) begin
          val_mem[pos] = rq.value;
          r.status = chtab_pkg::ST_UPDATED;
        end else begin
          link_mem[prv] = link_mem[pos];
          link_mem[pos] = free_ptr;
          free_ptr = 10'(pos);
          r.status = chtab_pkg::ST_REMOVED;
        end
      end else if (rq.kind == chtab_pkg::KIND_INSERT) begin
        if (in_overflow(free_ptr, nb)) begin
          pos = free_ptr;
          free_ptr = link_mem[pos];
          link_mem[pos] = link_mem[root];
          key_mem[pos] = rq.key;
          val_mem[pos] = rq.value;
          link_mem[root] = 10'(pos);
          r.status = chtab_pkg::ST_INSERTED;
        end else begin
          r.status = chtab_pkg::ST_FULL_CLR;
        end
      end
    end
    expected_rsp.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
    end
  end

  always @(posedge clk) begin
    chtab_pkg::rsp_t want;
    if (!rst_n) begin
      bucket_reg = 9'(chtab_pkg::BUCKET_RESET);
      rebuild_table();
      expected_rsp.delete();
    end else begin
      if (cfg_we) begin
        bucket_reg = cfg_wdata;
        rebuild_table();
      end
      if (in_valid && in_ready) apply_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", out_data.status, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.value_out !== want.value_out)
            report_mismatch("value_out", out_data.value_out, want.value_out);
        end
      end
    end
  end
endmodule

// ===== tb/chained_hash_table_engine_top_test.sv =====
module chained_hash_table_engine_top_test;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  chtab_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  chtab_pkg::rsp_t out_data;
  logic cfg_we = 0;
  logic [8:0] cfg_wdata = '0;
  int fail_count, pending;
  int cycle_count = 0;
  bit no_idle = 0;
  int hold_off = 0;
  logic [63:0] key_pool [16];

  always #5 clk = ~clk;

  chained_hash_table_engine_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  chained_hash_table_engine_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL chained_hash_table_engine_top");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on demand
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 0;
        hold_off--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready <= 0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // valid stays up after acceptance; the next call replaces the request or drops valid, or a drain takes it down
  task automatic send_request(chtab_pkg::kind_t k, logic [63:0] key, logic [63:0] val);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{kind: k, key: key, value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic write_buckets(logic [8:0] v);
    drain_and_settle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n);
    chtab_pkg::kind_t k;
    logic [63:0] key;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:39]:  k = chtab_pkg::KIND_INSERT;
        [40:69]: k = chtab_pkg::KIND_LOOKUP;
        [70:98]: k = chtab_pkg::KIND_REMOVE;
        default: k = chtab_pkg::KIND_CLEAR;
      endcase
      key = ($urandom_range(0, 3) == 0) ? rand64() : key_pool[$urandom_range(0, 15)];
      send_request(k, key, rand64());
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = rand64();
    repeat (5) @(negedge clk);
    rst_n <= 1;
    // directed: extremes, every kind, root removal with successor, full table
    send_request(chtab_pkg::KIND_LOOKUP, 64'h0, 64'h0);
    send_request(chtab_pkg::KIND_INSERT, 64'h0, '1);
    send_request(chtab_pkg::KIND_INSERT, '1, 64'h0);
    send_request(chtab_pkg::KIND_LOOKUP, 64'h0, 64'h0);
    send_request(chtab_pkg::KIND_INSERT, 64'h0, 64'h5a5a);
    send_request(chtab_pkg::KIND_LOOKUP, '1, 64'h0);
    send_request(chtab_pkg::KIND_REMOVE, 64'h0, 64'h0);
    send_request(chtab_pkg::KIND_REMOVE, 64'h0, 64'h0);
    send_request(chtab_pkg::KIND_CLEAR, '1, '1);
    send_request(chtab_pkg::KIND_LOOKUP, '1, 64'h0);
    write_buckets(9'd0);  // acts as 3 roots, 6 overflow entries
    for (int i = 0; i < 11; i++) send_request(chtab_pkg::KIND_INSERT, 64'(i), rand64());
    send_request(chtab_pkg::KIND_REMOVE, 64'd0, 64'h0);
    send_request(chtab_pkg::KIND_REMOVE, 64'd1, 64'h0);
    send_request(chtab_pkg::KIND_LOOKUP, 64'd2, 64'h0);
    send_request(chtab_pkg::KIND_INSERT, 64'd20, 64'h0);
    // random phases over several root counts; pool keeps chains busy
    write_buckets(9'd3);
    random_phase(300);
    write_buckets(9'd511);
    hold_off = 300;
    random_phase(300);
    write_buckets(9'd5);
    random_phase(300);
    write_buckets(9'd341);
    random_phase(300);
    write_buckets(9'd17);
    random_phase(225);
    no_idle = 1;
    random_phase(225);
    drain_and_settle();
    if (fail_count == 0) begin
      $display("PASS chained_hash_table_engine_top");
    end else begin
      $display("FAIL chained_hash_table_engine_top");
    end
    $finish;
  end
endmodule
